// ----- rtl/mbd_pkg.sv -----
// Package with the shared constants, codes and types of the multi-button debouncer.
`timescale 1ns / 1ps

package mbd_pkg;

    localparam int NUM_BUTTONS    = 5;
    localparam int TIME_WIDTH     = 32;
    localparam int DEBOUNCE_WIDTH = 16;
    localparam int CODE_WIDTH     = 2;
    localparam int MAP_WIDTH      = CODE_WIDTH * NUM_BUTTONS;
    localparam int CMP_WIDTH      = (TIME_WIDTH > DEBOUNCE_WIDTH) ? TIME_WIDTH : DEBOUNCE_WIDTH;
    localparam int CMD_WIDTH      = 2;
    localparam int ADDR_WIDTH     = 4;
    localparam int DATA_WIDTH     = 32;

    localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = DEBOUNCE_WIDTH'(30);
    localparam logic [MAP_WIDTH-1:0]      MAP_RESET      = MAP_WIDTH'(825);
    localparam logic [NUM_BUTTONS-1:0]    MASK_RESET     = NUM_BUTTONS'(8);

    localparam logic [CODE_WIDTH-1:0] CODE_NONE = CODE_WIDTH'(0);

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_POLL = 2'd0,
        CMD_INIT = 2'd1,
        CMD_TAKE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_DEBOUNCE    = 2'd0,
        REG_MESSAGE_MAP = 2'd1,
        REG_RESET_MASK  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [DEBOUNCE_WIDTH-1:0] debounce_time;
        logic [MAP_WIDTH-1:0]      message_map;
        logic [NUM_BUTTONS-1:0]    reset_mask;
    } t_cfg;

endpackage

// ----- rtl/mbd_regs.sv -----
// Configuration register file of the multi-button debouncer behind an APB-style port.
`timescale 1ns / 1ps

module mbd_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbd_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [mbd_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [mbd_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready,
    output mbd_pkg::t_cfg                   o_cfg
);

    mbd_pkg::t_cfg    r_cfg;
    mbd_pkg::t_reg_idx w_idx;

    assign w_idx  = mbd_pkg::t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= mbd_pkg::DEBOUNCE_RESET;
            r_cfg.message_map   <= mbd_pkg::MAP_RESET;
            r_cfg.reset_mask    <= mbd_pkg::MASK_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                mbd_pkg::REG_DEBOUNCE: begin
                    r_cfg.debounce_time <= pwdata[mbd_pkg::DEBOUNCE_WIDTH-1:0];
                end
                mbd_pkg::REG_MESSAGE_MAP: begin
                    r_cfg.message_map <= pwdata[mbd_pkg::MAP_WIDTH-1:0];
                end
                mbd_pkg::REG_RESET_MASK: begin
                    r_cfg.reset_mask <= pwdata[mbd_pkg::NUM_BUTTONS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            mbd_pkg::REG_DEBOUNCE:    prdata = mbd_pkg::DATA_WIDTH'(r_cfg.debounce_time);
            mbd_pkg::REG_MESSAGE_MAP: prdata = mbd_pkg::DATA_WIDTH'(r_cfg.message_map);
            mbd_pkg::REG_RESET_MASK:  prdata = mbd_pkg::DATA_WIDTH'(r_cfg.reset_mask);
            default:                  prdata = '0;
        endcase
    end

endmodule

// ----- rtl/multi_button_debouncer.sv -----
// Top level of the multi-button debouncer: input register, per-button update and result register.
// An accepted beat passes from the input register through the update into the result register.
// Throughput: one beat per cycle while the output is not stalled; all buttons update together.
// When empty, the input register takes a new beat while a finished result waits to be taken.
// Reset is synchronous and active low: it clears the pipeline and button state, arms every
// button and loads the configuration registers with their default values.
`timescale 1ns / 1ps

module multi_button_debouncer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mbd_pkg::CMD_WIDTH-1:0]     i_cmd,
    input  logic [mbd_pkg::NUM_BUTTONS-1:0]   i_raw_pressed,
    input  logic [mbd_pkg::TIME_WIDTH-1:0]    i_now_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mbd_pkg::CODE_WIDTH-1:0]    o_message,
    output logic [mbd_pkg::NUM_BUTTONS-1:0]   o_debounced,
    output logic                              o_reset_requested,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbd_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [mbd_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [mbd_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                              pready
);

    localparam int NB = mbd_pkg::NUM_BUTTONS;
    localparam int TW = mbd_pkg::TIME_WIDTH;
    localparam int CW = mbd_pkg::CODE_WIDTH;

    mbd_pkg::t_cfg w_cfg;

    logic                 r_in_valid;
    logic [mbd_pkg::CMD_WIDTH-1:0] r_in_cmd;
    logic [NB-1:0]        r_in_raw;
    logic [TW-1:0]        r_in_now;

    logic                 r_out_valid;
    logic [CW-1:0]        r_out_message;
    logic [NB-1:0]        r_out_stable;
    logic                 r_out_req;

    logic [NB-1:0]        r_last;
    logic [NB-1:0]        r_stable;
    logic [NB-1:0]        r_armed;
    logic [TW-1:0]        r_change [NB];
    logic                 r_flag;

    logic [NB-1:0]        n_last;
    logic [NB-1:0]        n_stable;
    logic [NB-1:0]        n_armed;
    logic [TW-1:0]        n_change [NB];
    logic                 n_flag;
    logic [CW-1:0]        n_message;
    logic                 n_req;
    logic [NB-1:0]        w_press;

    logic                 w_out_free;
    logic                 w_fire;
    logic                 w_accept;

    mbd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cmd <= i_cmd;
            r_in_raw <= i_raw_pressed;
            r_in_now <= i_now_ms;
        end
    end

    always_comb begin
        logic [TW-1:0] v_ct;
        logic [TW-1:0] v_elapsed;

        n_last    = r_last;
        n_stable  = r_stable;
        n_armed   = r_armed;
        n_change  = r_change;
        n_flag    = r_flag;
        n_message = mbd_pkg::CODE_NONE;
        n_req     = 1'b0;
        w_press   = '0;
        v_ct      = '0;
        v_elapsed = '0;

        unique case (mbd_pkg::t_cmd'(r_in_cmd))
            mbd_pkg::CMD_POLL: begin
                for (int i = 0; i < NB; i++) begin
                    v_ct      = (r_in_raw[i] != r_last[i]) ? r_in_now : r_change[i];
                    v_elapsed = r_in_now - v_ct;
                    n_last[i]   = r_in_raw[i];
                    n_change[i] = v_ct;
                    if ((r_in_raw[i] != r_stable[i]) &&
                        (mbd_pkg::CMP_WIDTH'(v_elapsed) >=
                         mbd_pkg::CMP_WIDTH'(w_cfg.debounce_time))) begin
                        n_stable[i] = r_in_raw[i];
                        if (r_in_raw[i]) begin
                            if (r_armed[i]) begin
                                w_press[i] = 1'b1;
                                if (w_cfg.reset_mask[i]) begin
                                    n_flag = 1'b1;
                                end
                            end
                        end else begin
                            n_armed[i] = 1'b1;
                        end
                    end
                end
                // Walk downwards so that the lowest-index button with a code wins.
                for (int i = NB - 1; i >= 0; i--) begin
                    if (w_press[i] && (w_cfg.message_map[CW*i +: CW] != mbd_pkg::CODE_NONE)) begin
                        n_message = w_cfg.message_map[CW*i +: CW];
                    end
                end
            end
            mbd_pkg::CMD_INIT: begin
                n_last   = r_in_raw;
                n_stable = r_in_raw;
                n_armed  = ~r_in_raw;
                for (int i = 0; i < NB; i++) begin
                    n_change[i] = r_in_now;
                end
                n_flag = 1'b0;
            end
            mbd_pkg::CMD_TAKE: begin
                n_req  = r_flag;
                n_flag = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_stable <= '0;
            r_armed  <= '1;
            r_flag   <= 1'b0;
            for (int i = 0; i < NB; i++) begin
                r_change[i] <= '0;
            end
        end else if (w_fire) begin
            r_last   <= n_last;
            r_stable <= n_stable;
            r_armed  <= n_armed;
            r_flag   <= n_flag;
            r_change <= n_change;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_message <= n_message;
            r_out_stable  <= n_stable;
            r_out_req     <= n_req;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_message         = r_out_message;
    assign o_debounced       = r_out_stable;
    assign o_reset_requested = r_out_req;

endmodule

// ----- rtl/mbd_checker.sv -----
// Port-level checker of the multi-button debouncer and its bind to the top level.
`timescale 1ns / 1ps

module mbd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic [mbd_pkg::CODE_WIDTH-1:0]    o_message,
    input  logic [mbd_pkg::NUM_BUTTONS-1:0]   o_debounced,
    input  logic                              o_reset_requested
);

    // A result that is not taken holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_message) && $stable(o_debounced) &&
            $stable(o_reset_requested))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // With no result waiting, the input side always takes a beat.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // A reported reset request comes from a take beat, which carries no message.
    a_req_no_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reset_requested |-> o_message == mbd_pkg::CODE_NONE)
        else $error("reset request reported together with a message");

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_message         (o_message),
    .o_debounced       (o_debounced),
    .o_reset_requested (o_reset_requested)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the multi-button debouncer, with its own debounce predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int NB  = mbd_pkg::NUM_BUTTONS;
    localparam int TW  = mbd_pkg::TIME_WIDTH;
    localparam int CW  = mbd_pkg::CODE_WIDTH;
    localparam int CMW = mbd_pkg::CMD_WIDTH;
    localparam int AW  = mbd_pkg::ADDR_WIDTH;
    localparam int DW  = mbd_pkg::DATA_WIDTH;

    localparam logic [CMW-1:0] CMD_UNUSED    = 2'd3;
    localparam logic [AW-1:0]  ADDR_UNMAPPED = 4'd12;
    localparam int unsigned    CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [CW-1:0] message;
        logic [NB-1:0] stable;
        logic          requested;
    } t_poll_report;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    logic [CMW-1:0] i_cmd = mbd_pkg::CMD_POLL;
    logic [NB-1:0]  i_raw_pressed = '0;
    logic [TW-1:0]  i_now_ms = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    logic [CW-1:0]  o_message;
    logic [NB-1:0]  o_debounced;
    logic           o_reset_requested;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [AW-1:0]  paddr = '0;
    logic [DW-1:0]  pwdata = '0;
    logic [DW-1:0]  prdata;
    logic           pready;

    logic [mbd_pkg::DEBOUNCE_WIDTH-1:0] cfg_debounce = mbd_pkg::DEBOUNCE_RESET;
    logic [mbd_pkg::MAP_WIDTH-1:0]      cfg_map      = mbd_pkg::MAP_RESET;
    logic [NB-1:0]                      cfg_mask     = mbd_pkg::MASK_RESET;

    logic [NB-1:0] prev_raw  = '0;
    logic [NB-1:0] settled   = '0;
    logic [NB-1:0] armed_btn = '1;
    logic [TW-1:0] stamp_ms [NB] = '{default: '0};
    logic          reset_req = 1'b0;

    t_poll_report pending_reports[$];
    t_poll_report due;

    logic        idle_mode = 1'b1;
    logic        hold_toggle = 1'b0;
    logic        hold_ack = 1'b0;
    int unsigned hold_len = 0;
    int unsigned hold_left = 0;
    int unsigned recv_wait = 0;
    int unsigned recv_draw;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    multi_button_debouncer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_raw_pressed     (i_raw_pressed),
        .i_now_ms          (i_now_ms),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_message         (o_message),
        .o_debounced       (o_debounced),
        .o_reset_requested (o_reset_requested),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [AW-1:0] reg_addr(input logic [1:0] idx);
        return AW'(idx) << 2;
    endfunction

    function automatic t_poll_report debounce_predict(input logic [CMW-1:0] cmd,
                                                      input logic [NB-1:0] raw,
                                                      input logic [TW-1:0] now);
        t_poll_report  res;
        logic [TW-1:0] elapsed;
        logic [CW-1:0] code;
        res = '0;
        case (cmd)
            mbd_pkg::CMD_POLL: begin
                for (int b = 0; b < NB; b++) begin
                    if (raw[b] != prev_raw[b]) begin
                        prev_raw[b] = raw[b];
                        stamp_ms[b] = now;
                    end
                    elapsed = now - stamp_ms[b];
                    if (raw[b] != settled[b] && elapsed >= TW'(cfg_debounce)) begin
                        settled[b] = raw[b];
                        if (!raw[b]) begin
                            armed_btn[b] = 1'b1;
                        end else if (armed_btn[b]) begin
                            code = cfg_map[2*b +: CW];
                            if (cfg_mask[b]) reset_req = 1'b1;
                            if (code != mbd_pkg::CODE_NONE &&
                                res.message == mbd_pkg::CODE_NONE) res.message = code;
                        end
                    end
                end
            end
            mbd_pkg::CMD_INIT: begin
                prev_raw  = raw;
                settled   = raw;
                armed_btn = ~raw;
                for (int b = 0; b < NB; b++) stamp_ms[b] = now;
                reset_req = 1'b0;
            end
            mbd_pkg::CMD_TAKE: begin
                res.requested = reset_req;
                reset_req     = 1'b0;
            end
            default: ;
        endcase
        res.stable = settled;
        return res;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_beat(input logic [CMW-1:0] cmd,
                             input logic [NB-1:0] raw,
                             input logic [TW-1:0] now);
        int unsigned gap;
        gap = idle_mode ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_raw_pressed <= raw;
        i_now_ms      <= now;
        do @(posedge i_clk); while (!o_in_ready);
        pending_reports.push_back(debounce_predict(cmd, raw, now));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [AW-1:0] addr, input logic [DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == reg_addr(mbd_pkg::REG_DEBOUNCE)) begin
            cfg_debounce = data[mbd_pkg::DEBOUNCE_WIDTH-1:0];
        end else if (addr == reg_addr(mbd_pkg::REG_MESSAGE_MAP)) begin
            cfg_map = data[mbd_pkg::MAP_WIDTH-1:0];
        end else if (addr == reg_addr(mbd_pkg::REG_RESET_MASK)) begin
            cfg_mask = data[NB-1:0];
        end
        @(posedge i_clk);
    endtask

    task automatic bouncing_presses(input int unsigned count, input logic [TW-1:0] start_ms);
        logic [TW-1:0] clock_ms;
        logic [NB-1:0] level;
        int unsigned   pick;
        int unsigned   span;
        clock_ms = start_ms;
        level    = NB'($urandom_range(0, 31));
        send_beat(mbd_pkg::CMD_INIT, level, clock_ms);
        repeat (count) begin
            pick     = $urandom_range(0, 99);
            span     = (cfg_debounce >> 2) + 3;
            clock_ms = clock_ms + $urandom_range(0, span);
            if ($urandom_range(0, 49) == 0) clock_ms = clock_ms + $urandom;
            if ($urandom_range(0, 5) == 0) level = level ^ NB'(1 << $urandom_range(0, 4));
            if ($urandom_range(0, 19) == 0) level = NB'($urandom_range(0, 31));
            if (pick < 84) send_beat(mbd_pkg::CMD_POLL, level, clock_ms);
            else if (pick < 92) send_beat(mbd_pkg::CMD_TAKE, NB'($urandom), $urandom);
            else if (pick < 95) send_beat(mbd_pkg::CMD_INIT, level, clock_ms);
            else if (pick < 97) send_beat(CMD_UNUSED, NB'($urandom), $urandom);
            else send_beat(mbd_pkg::CMD_POLL, NB'($urandom), $urandom);
        end
    endtask

    task automatic test_default_settings();
        send_beat(CMD_UNUSED, 5'b11111, 32'd5);
        send_beat(mbd_pkg::CMD_POLL, 5'b01000, 32'd100);
        send_beat(mbd_pkg::CMD_POLL, 5'b01000, 32'd129);
        send_beat(mbd_pkg::CMD_POLL, 5'b01000, 32'd130);
        send_beat(mbd_pkg::CMD_TAKE, 5'b00000, 32'd131);
        send_beat(mbd_pkg::CMD_TAKE, 5'b00000, 32'd132);
        send_beat(mbd_pkg::CMD_POLL, 5'b11111, 32'd200);
        send_beat(mbd_pkg::CMD_POLL, 5'b11111, 32'd230);
        send_beat(mbd_pkg::CMD_POLL, 5'b00000, 32'd300);
        send_beat(mbd_pkg::CMD_POLL, 5'b00000, 32'd330);
        send_beat(mbd_pkg::CMD_POLL, 5'b00010, 32'd400);
        send_beat(mbd_pkg::CMD_POLL, 5'b00000, 32'd410);
        send_beat(mbd_pkg::CMD_POLL, 5'b00010, 32'd420);
        send_beat(mbd_pkg::CMD_POLL, 5'b00010, 32'd450);
        send_beat(mbd_pkg::CMD_POLL, 5'b10000, 32'hFFFF_FFF0);
        send_beat(mbd_pkg::CMD_POLL, 5'b10000, 32'h0000_000E);
        wait_drained();
    endtask

    task automatic test_extreme_settings();
        cfg_write(reg_addr(mbd_pkg::REG_DEBOUNCE), 32'd0);
        cfg_write(reg_addr(mbd_pkg::REG_MESSAGE_MAP), 32'd1023);
        cfg_write(reg_addr(mbd_pkg::REG_RESET_MASK), 32'd31);
        cfg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        send_beat(mbd_pkg::CMD_INIT, 5'b00000, 32'd0);
        send_beat(mbd_pkg::CMD_POLL, 5'b00001, 32'd1);
        send_beat(mbd_pkg::CMD_POLL, 5'b00000, 32'd1);
        send_beat(mbd_pkg::CMD_POLL, 5'b11111, 32'hFFFF_FFFF);
        send_beat(mbd_pkg::CMD_TAKE, 5'b11111, 32'hFFFF_FFFF);
        send_beat(CMD_UNUSED, 5'b00000, 32'd0);
        wait_drained();
        cfg_write(reg_addr(mbd_pkg::REG_DEBOUNCE), 32'hFFFF_FFFF);
        send_beat(mbd_pkg::CMD_POLL, 5'b00000, 32'd10);
        send_beat(mbd_pkg::CMD_POLL, 5'b00000, 32'd65544);
        send_beat(mbd_pkg::CMD_POLL, 5'b00000, 32'd65545);
        send_beat(mbd_pkg::CMD_INIT, 5'b11111, 32'hFFFF_0000);
        send_beat(mbd_pkg::CMD_POLL, 5'b00000, 32'hFFFF_FFFF);
        send_beat(mbd_pkg::CMD_POLL, 5'b00000, 32'h0000_FFFF);
        wait_drained();
    endtask

    task automatic test_random_settings();
        logic [DW-1:0] hold_ms;
        logic [DW-1:0] code_map;
        logic [DW-1:0] req_mask;
        logic [TW-1:0] start_ms;
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    hold_ms  = 32'd0;
                    code_map = 32'd1023;
                    req_mask = 32'd31;
                    start_ms = 32'd0;
                end
                1: begin
                    hold_ms  = 32'd65535;
                    code_map = 32'd0;
                    req_mask = 32'd0;
                    start_ms = 32'hFFFF_0000;
                end
                2: begin
                    hold_ms  = 32'd30;
                    code_map = 32'd825;
                    req_mask = 32'd8;
                    start_ms = $urandom;
                end
                default: begin
                    hold_ms  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 120);
                    code_map = $urandom;
                    req_mask = $urandom;
                    start_ms = $urandom;
                end
            endcase
            idle_mode <= (phase != 3 && phase != 6);
            cfg_write(reg_addr(mbd_pkg::REG_DEBOUNCE), hold_ms);
            cfg_write(reg_addr(mbd_pkg::REG_MESSAGE_MAP), code_map);
            cfg_write(reg_addr(mbd_pkg::REG_RESET_MASK), req_mask);
            bouncing_presses(172, start_ms);
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        cfg_write(reg_addr(mbd_pkg::REG_DEBOUNCE), 32'd4);
        idle_mode   <= 1'b0;
        hold_len    <= 120;
        hold_toggle <= ~hold_toggle;
        bouncing_presses(30, 32'd1000);
        wait_drained();
        idle_mode <= 1'b1;
        bouncing_presses(12, 32'd5000);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_wait   <= 0;
            hold_left   <= 0;
        end else if (hold_toggle != hold_ack) begin
            hold_ack    <= hold_toggle;
            hold_left   <= hold_len;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (i_out_ready && o_out_valid) begin
            recv_draw    = idle_mode ? $urandom_range(0, 3) : 0;
            recv_wait   <= recv_draw;
            i_out_ready <= (recv_draw == 0);
        end else if (recv_wait != 0) begin
            recv_wait   <= recv_wait - 1;
            i_out_ready <= (recv_wait == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t ns: unexpected result beat, expected none, actual %0d/%b/%b",
                         $time, o_message, o_debounced, o_reset_requested);
                mismatch_count++;
            end else begin
                due = pending_reports.pop_front();
                check_field("message", due.message, o_message);
                check_field("debounced", due.stable, o_debounced);
                check_field("reset_requested", due.requested, o_reset_requested);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_settings();
        test_extreme_settings();
        test_random_settings();
        test_output_backpressure();
        wait_drained();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
